// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the trie core; they compile away
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication property on the rising clock, off during reset
`define BTMX_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("btmx assertion failed");

// Check that a condition never holds on the rising clock, off during reset
`define BTMX_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("btmx forbidden condition");

`else

`define BTMX_ASSERT(label, clk, rst_n, prop)
`define BTMX_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: rtl/core/btmx_pkg.sv
// ----------------------------------------------------------------------------
// btmx_pkg
// Types, codes and defaults shared by the binary trie max-xor core.
// ----------------------------------------------------------------------------
`default_nettype none

package btmx_pkg;

  // Field widths of the request and result
  localparam int KEY_W  = 40;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;

  // Parameter defaults
  localparam int KEY_BITS_DEF   = 40;
  localparam int NODE_COUNT_DEF = 65536;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] key;
  } btmx_in_t;

  typedef struct packed {
    logic [KEY_W-1:0]  max_xor;
    logic [STAT_W-1:0] status;
  } btmx_out_t;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } btmx_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              start_walk;
    logic              walk_query;
    logic              step;
    logic              clear;
    logic              reply;
    logic [STAT_W-1:0] reply_status;
  } btmx_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic trie_empty;
    logic store_full;
    logic last_level;
  } btmx_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/btmx_ram.sv
// ----------------------------------------------------------------------------
// btmx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/btmx_ctrl.sv
// ----------------------------------------------------------------------------
// btmx_ctrl
// Request sequencer: decodes a request, answers short ones at once and
// steps the datapath through one trie level per cycle for insert and query.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [btmx_pkg::REQ_W-1:0]  req_type,
  input  wire btmx_pkg::btmx_stat_t        stat,
  output logic                             busy,
  output btmx_pkg::btmx_cmd_t              cmd
);

  btmx_pkg::btmx_state_t state_r, state_nxt;
  logic                  walk_query_r, walk_query_nxt;

  // State and mode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= btmx_pkg::S_IDLE;
      walk_query_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      walk_query_r <= walk_query_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt        = state_r;
    walk_query_nxt   = walk_query_r;
    cmd              = '0;
    cmd.reply_status = btmx_pkg::STAT_OK;
    case (state_r)
      btmx_pkg::S_IDLE: begin
        cmd.walk_query = (req_type == btmx_pkg::REQ_QUERY);
        if (start) begin
          case (req_type)
            btmx_pkg::REQ_INSERT: begin
              if (stat.store_full) begin
                cmd.reply        = 1'b1;
                cmd.reply_status = btmx_pkg::STAT_FULL;
              end else begin
                cmd.start_walk = 1'b1;
                walk_query_nxt = 1'b0;
                state_nxt      = btmx_pkg::S_WALK;
              end
            end
            btmx_pkg::REQ_QUERY: begin
              if (stat.trie_empty) begin
                cmd.reply        = 1'b1;
                cmd.reply_status = btmx_pkg::STAT_EMPTY;
              end else begin
                cmd.start_walk = 1'b1;
                walk_query_nxt = 1'b1;
                state_nxt      = btmx_pkg::S_WALK;
              end
            end
            btmx_pkg::REQ_CLEAR: begin
              cmd.clear = 1'b1;
              cmd.reply = 1'b1;
            end
            default: begin
              // unused code: answer ok, touch nothing
              cmd.reply = 1'b1;
            end
          endcase
        end
      end
      btmx_pkg::S_WALK: begin
        cmd.step       = 1'b1;
        cmd.walk_query = walk_query_r;
        if (stat.last_level) begin
          cmd.reply = 1'b1;
          state_nxt = btmx_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = btmx_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != btmx_pkg::S_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/btmx_dpath.sv
// ----------------------------------------------------------------------------
// btmx_dpath
// Trie datapath: root children, free-node pointer, node store and the
// one-level-per-cycle walk used by insert and query.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_dpath #(
  parameter int KEY_BITS   = btmx_pkg::KEY_BITS_DEF,
  parameter int NODE_COUNT = btmx_pkg::NODE_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire btmx_pkg::btmx_in_t  in_req,
  input  wire btmx_pkg::btmx_cmd_t cmd,
  output btmx_pkg::btmx_stat_t     stat,
  output logic                     out_valid,
  output btmx_pkg::btmx_out_t      out_res
);

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int FREE_W = $clog2(NODE_COUNT + 1);
  localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int ENT_W  = 2 * NODE_W;
  localparam logic [FREE_W-1:0] FULL_LIMIT = FREE_W'(NODE_COUNT - KEY_BITS);
  localparam logic [LVL_W-1:0]  TOP_LEVEL  = LVL_W'(KEY_BITS - 1);

  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] acc_r, acc_nxt;
  logic [LVL_W-1:0]    level_r;
  logic [NODE_W-1:0]   cur_r;
  logic                at_root_r;
  logic                fresh_r;
  logic [NODE_W-1:0]   root0_r, root1_r;
  logic [FREE_W-1:0]   next_free_r;
  logic                out_valid_r;
  btmx_pkg::btmx_out_t out_r;

  logic [ENT_W-1:0]    rd_data, kids, ram_wdata;
  logic [NODE_W-1:0]   kid0, kid1, same_kid, opp_kid, alloc_idx, nx;
  logic                bit_b, take_opp, alloc, ram_we;

  // Node store: one entry holds both child indices, child 1 on top
  btmx_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NODE_COUNT)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (cur_r),
    .wdata   (ram_wdata),
    .raddr   (nx),
    .rdata_r (rd_data)
  );

  // One trie level: pick the children, choose or allocate the next node
  always_comb begin
    bit_b = key_r[level_r];
    if (at_root_r) begin
      kids = {root1_r, root0_r};
    end else if (fresh_r || (cur_r == '0)) begin
      // new node or null node: no children
      kids = '0;
    end else begin
      kids = rd_data;
    end
    kid0      = kids[NODE_W-1:0];
    kid1      = kids[ENT_W-1:NODE_W];
    same_kid  = bit_b ? kid1 : kid0;
    opp_kid   = bit_b ? kid0 : kid1;
    alloc_idx = next_free_r[NODE_W-1:0];
    take_opp  = (opp_kid != '0);
    alloc     = !cmd.walk_query && (same_kid == '0);
    acc_nxt   = acc_r;
    nx        = same_kid;
    if (cmd.walk_query) begin
      if (take_opp) begin
        nx               = opp_kid;
        acc_nxt[level_r] = 1'b1;
      end
    end else if (alloc) begin
      nx = alloc_idx;
    end
    ram_we    = cmd.step && alloc && !at_root_r;
    ram_wdata = bit_b ? {alloc_idx, kid0} : {kid1, alloc_idx};
  end

  // Trie bookkeeping, walk control and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root0_r     <= '0;
      root1_r     <= '0;
      next_free_r <= FREE_W'(1);
      out_valid_r <= 1'b0;
      level_r     <= '0;
      at_root_r   <= 1'b1;
      fresh_r     <= 1'b0;
    end else begin
      out_valid_r <= cmd.reply;
      if (cmd.clear) begin
        root0_r     <= '0;
        root1_r     <= '0;
        next_free_r <= FREE_W'(1);
      end else if (cmd.step && alloc) begin
        next_free_r <= next_free_r + FREE_W'(1);
        if (at_root_r) begin
          if (bit_b) begin
            root1_r <= alloc_idx;
          end else begin
            root0_r <= alloc_idx;
          end
        end
      end
      if (cmd.start_walk) begin
        level_r   <= TOP_LEVEL;
        at_root_r <= 1'b1;
        fresh_r   <= 1'b0;
      end else if (cmd.step) begin
        level_r   <= level_r - LVL_W'(1);
        at_root_r <= 1'b0;
        fresh_r   <= fresh_r | alloc;
      end
    end
  end

  // Walk payload and result fields
  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      key_r <= KEY_BITS'(in_req.key);
      cur_r <= '0;
      acc_r <= '0;
    end else if (cmd.step) begin
      cur_r <= nx;
      acc_r <= acc_nxt;
    end
    if (cmd.reply) begin
      out_r.max_xor <= (cmd.step && cmd.walk_query) ? btmx_pkg::KEY_W'(acc_nxt) : '0;
      out_r.status  <= cmd.reply_status;
    end
  end

  assign stat.trie_empty = (root0_r == '0) && (root1_r == '0);
  assign stat.store_full = (next_free_r > FULL_LIMIT);
  assign stat.last_level = (level_r == '0);
  assign out_valid       = out_valid_r;
  assign out_res         = out_r;

endmodule

`default_nettype wire

// File: rtl/core/binary_trie_max_xor_core.sv
// ----------------------------------------------------------------------------
// binary_trie_max_xor_core
// Bitwise trie of KEY_BITS-bit keys answering insert, maximum-XOR query and
// clear requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on out_res for exactly one cycle with out_valid high, and the
// receiver cannot stall it. Insert and query walk the trie one level per
// cycle, one node-store read per level with registered read data, and keep
// busy high until the last level, so no new request is taken meanwhile; the
// result strobes in the cycle busy falls. Clear, the unused request code, a
// query on an empty trie and an insert refused for lack of KEY_BITS free
// nodes answer in the next cycle and never raise busy.
// The node store needs no clearing pass after reset or clear: a node entry is
// written before it is ever read.
`default_nettype none

`include "assert_macros.svh"

module binary_trie_max_xor_core #(
  parameter int KEY_BITS   = btmx_pkg::KEY_BITS_DEF,
  parameter int NODE_COUNT = btmx_pkg::NODE_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire btmx_pkg::btmx_in_t  in_req,
  output logic                     out_valid,
  output btmx_pkg::btmx_out_t      out_res
);

  btmx_pkg::btmx_cmd_t  cmd;
  btmx_pkg::btmx_stat_t stat;

  // Request sequencer
  btmx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req.req_type),
    .stat     (stat),
    .busy     (busy),
    .cmd      (cmd)
  );

  // Trie datapath and node store
  btmx_dpath #(
    .KEY_BITS   (KEY_BITS),
    .NODE_COUNT (NODE_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // Every result strobe follows a reply command
  `BTMX_ASSERT(a_strobe_from_reply, clk, rst_n, out_valid |-> $past(cmd.reply))

  // No new walk starts while one is in flight
  `BTMX_NEVER(a_no_start_when_busy, clk, rst_n, busy && cmd.start_walk)

  // A query on an empty trie answers next cycle with the empty status
  `BTMX_ASSERT(a_empty_query, clk, rst_n, (start && !busy && stat.trie_empty && (in_req.req_type == btmx_pkg::REQ_QUERY)) |=> (out_valid && (out_res.status == btmx_pkg::STAT_EMPTY)))

  // A walk never finishes without a result strobe next cycle
  `BTMX_ASSERT(a_walk_replies, clk, rst_n, (busy && stat.last_level) |=> out_valid)

endmodule

`default_nettype wire

// File: bench/binary_trie_max_xor_core_tb.sv
// ----------------------------------------------------------------------------
// binary_trie_max_xor_core_tb
// Self-checking bench for the trie max-xor core: a scoreboard keeps its own
// copy of the trie, works out each result as requests are taken, and checks
// every strobed result in order. Directed corner requests come first, then
// mixed insert/query/clear traffic under several idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

// Scoreboard: shadow trie plus the queue of results still due
class trie_scoreboard;
  localparam int LEVELS = btmx_pkg::KEY_BITS_DEF;
  localparam int NODES  = btmx_pkg::NODE_COUNT_DEF;

  int unsigned kids [NODES][2];
  int unsigned root_kid [2];
  int unsigned next_node;
  btmx_pkg::btmx_out_t awaited [$];
  int errors;
  int checked;
  int by_kind [4];
  int by_status [4];

  function new();
    root_kid[0] = 0;
    root_kid[1] = 0;
    next_node   = 1;
    errors      = 0;
    checked     = 0;
    for (int k = 0; k < 4; k++) begin
      by_kind[k]   = 0;
      by_status[k] = 0;
    end
  endfunction

  // Child index of a node; the root sits outside the node store
  function int unsigned child(bit at_root, int unsigned node, bit b);
    if (at_root) return root_kid[b];
    if (node == 0 || node >= NODES) return 0;
    return kids[node][b];
  endfunction

  function int free_nodes();
    return NODES - int'(next_node);
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  // Apply one accepted request to the shadow trie and queue its result
  function void note_request(btmx_pkg::btmx_in_t r);
    btmx_pkg::btmx_out_t res;
    int unsigned cur;
    int unsigned nx;
    int unsigned opp;
    bit at_root;
    bit b;
    res = '0;
    res.status = btmx_pkg::STAT_OK;
    cur = 0;
    at_root = 1'b1;
    by_kind[r.req_type]++;
    case (r.req_type)
      btmx_pkg::REQ_INSERT: begin
        // refuse the whole insert unless a full path could be allocated
        if (NODES - next_node < LEVELS) begin
          res.status = btmx_pkg::STAT_FULL;
        end else begin
          for (int i = LEVELS - 1; i >= 0; i--) begin
            b = r.key[i];
            nx = child(at_root, cur, b);
            if (nx == 0) begin
              nx = next_node;
              if (nx == 0 || nx >= NODES) begin
                res.status = btmx_pkg::STAT_FULL;
                break;
              end
              next_node = nx + 1;
              kids[nx][0] = 0;
              kids[nx][1] = 0;
              if (at_root) root_kid[b] = nx;
              else if (cur != 0 && cur < NODES) kids[cur][b] = nx;
            end
            cur = nx;
            at_root = 1'b0;
          end
        end
      end
      btmx_pkg::REQ_QUERY: begin
        if (root_kid[0] == 0 && root_kid[1] == 0) begin
          res.status = btmx_pkg::STAT_EMPTY;
        end else begin
          // prefer the opposite bit at every level
          for (int i = LEVELS - 1; i >= 0; i--) begin
            b = r.key[i];
            opp = child(at_root, cur, ~b);
            if (opp != 0) begin
              res.max_xor[i] = 1'b1;
              cur = opp;
            end else begin
              cur = child(at_root, cur, b);
            end
            at_root = 1'b0;
          end
        end
      end
      btmx_pkg::REQ_CLEAR: begin
        root_kid[0] = 0;
        root_kid[1] = 0;
        next_node = 1;
      end
      default: ;
    endcase
    awaited.push_back(res);
  endfunction

  // Compare a strobed result with the oldest one due
  function void check_result(btmx_pkg::btmx_out_t got);
    btmx_pkg::btmx_out_t exp;
    if (awaited.size() == 0) begin
      $error("result with no request waiting: max_xor %h status %0d",
             got.max_xor, got.status);
      errors++;
      return;
    end
    exp = awaited.pop_front();
    checked++;
    by_status[exp.status]++;
    if (got.max_xor !== exp.max_xor) begin
      $error("max_xor: expected %h, got %h", exp.max_xor, got.max_xor);
      errors++;
    end
    if (got.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, got.status);
      errors++;
    end
  endfunction
endclass

module binary_trie_max_xor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_BITS   = btmx_pkg::KEY_BITS_DEF;
  localparam int NODE_COUNT = btmx_pkg::NODE_COUNT_DEF;
  localparam logic [btmx_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned LIMIT = 1_000_000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  btmx_pkg::btmx_in_t  in_req;
  logic                out_valid;
  btmx_pkg::btmx_out_t out_res;

  trie_scoreboard sb = new();

  int                         idle_pct;
  int unsigned                cycles = 0;
  logic [btmx_pkg::KEY_W-1:0] stored_keys [$];

  binary_trie_max_xor_core #(
    .KEY_BITS  (KEY_BITS),
    .NODE_COUNT(NODE_COUNT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("binary_trie_max_xor_core_tb failed");
      $finish;
    end
  end

  // Record taken requests, then check strobed results
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_req);
      if (out_valid) sb.check_result(out_res);
    end
  end

  function automatic logic [btmx_pkg::KEY_W-1:0] random_key();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[btmx_pkg::KEY_W-1:0];
  endfunction

  // Insert keys: dense, one-hot, near a stored key, or runs of ones/zeros
  function automatic logic [btmx_pkg::KEY_W-1:0] pick_key();
    logic [btmx_pkg::KEY_W-1:0] r;
    logic [btmx_pkg::KEY_W-1:0] k;
    r = random_key();
    case ($urandom_range(3))
      0: k = r;
      1: k = btmx_pkg::KEY_W'(1) << $urandom_range(btmx_pkg::KEY_W - 1);
      2: begin
        if (stored_keys.size() != 0)
          k = stored_keys[$urandom_range(stored_keys.size() - 1)]
              ^ (r >> $urandom_range(btmx_pkg::KEY_W - 1));
        else
          k = r;
      end
      default: begin
        k = r >> $urandom_range(btmx_pkg::KEY_W - 1);
        if ($urandom_range(1) == 1) k = ~k;
      end
    endcase
    return k;
  endfunction

  // Query targets: stored keys, their complements, near misses, noise
  function automatic logic [btmx_pkg::KEY_W-1:0] pick_target();
    logic [btmx_pkg::KEY_W-1:0] k;
    k = (stored_keys.size() == 0) ? random_key()
        : stored_keys[$urandom_range(stored_keys.size() - 1)];
    case ($urandom_range(4))
      0: k = random_key();
      1: k = k ^ (random_key() >> $urandom_range(btmx_pkg::KEY_W - 1));
      2: k = ~k;
      3: ;
      default: k = pick_key();
    endcase
    return k;
  endfunction

  // Issue one request, with an optional idle gap ahead of it
  task automatic send(input logic [btmx_pkg::REQ_W-1:0] kind,
                      input logic [btmx_pkg::KEY_W-1:0] key);
    btmx_pkg::btmx_in_t r;
    int gap;
    r.req_type = kind;
    r.key = key;
    if ($urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(45, 4) : $urandom_range(3, 1);
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_req = r;
    do @(posedge clk); while (busy);
    @(negedge clk);
    case (kind)
      btmx_pkg::REQ_INSERT: stored_keys.push_back(key);
      btmx_pkg::REQ_CLEAR:  stored_keys.delete();
      default: ;
    endcase
  endtask

  // Hold off until every result due has come back
  task automatic drain();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Mixed traffic: grow tries, query them, clear now and then
  task automatic run_mix(input int count);
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (stored_keys.size() == 0) begin
        if (pick < 20) send(btmx_pkg::REQ_QUERY, pick_key());
        else send(btmx_pkg::REQ_INSERT, pick_key());
      end else if (pick < 35) begin
        send(btmx_pkg::REQ_INSERT, pick_key());
      end else if (pick < 88) begin
        send(btmx_pkg::REQ_QUERY, pick_target());
      end else if (pick < 93) begin
        send(btmx_pkg::REQ_CLEAR, random_key());
      end else begin
        send(REQ_UNUSED, random_key());
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    idle_pct = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed corners: empty trie, extreme keys, unused code, clears
    send(btmx_pkg::REQ_QUERY,  '0);
    send(REQ_UNUSED,           '1);
    send(btmx_pkg::REQ_CLEAR,  '0);
    send(btmx_pkg::REQ_INSERT, '0);
    send(btmx_pkg::REQ_QUERY,  '0);
    send(btmx_pkg::REQ_QUERY,  '1);
    send(btmx_pkg::REQ_INSERT, '1);
    send(btmx_pkg::REQ_QUERY,  '0);
    send(btmx_pkg::REQ_QUERY,  40'h55_5555_5555);
    send(btmx_pkg::REQ_INSERT, 40'h80_0000_0000);
    send(btmx_pkg::REQ_INSERT, 40'h00_0000_0001);
    send(btmx_pkg::REQ_QUERY,  40'h7f_ffff_ffff);
    send(btmx_pkg::REQ_INSERT, '1);
    send(REQ_UNUSED,           40'h12_3456_789a);
    send(btmx_pkg::REQ_QUERY,  '1);
    send(btmx_pkg::REQ_CLEAR,  '1);
    send(btmx_pkg::REQ_QUERY,  '1);
    send(REQ_UNUSED,           '0);
    send(btmx_pkg::REQ_INSERT, 40'ha5_a5a5_a5a5);
    send(btmx_pkg::REQ_QUERY,  40'ha5_a5a5_a5a5);
    send(btmx_pkg::REQ_QUERY,  40'h5a_5a5a_5a5a);
    send(btmx_pkg::REQ_CLEAR,  '0);
    send(btmx_pkg::REQ_CLEAR,  '0);
    drain();

    // Sender idles often
    idle_pct = 18;
    run_mix(283);
    drain();

    // Sender idles most of the time
    idle_pct = 68;
    send(btmx_pkg::REQ_CLEAR, '0);
    run_mix(283);
    drain();

    // No idling at all
    idle_pct = 0;
    run_mix(284);
    drain();
    repeat (KEY_BITS + 8) @(negedge clk);

    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end
    $display("run: %0d inserts, %0d queries, %0d clears, %0d unused-code requests",
             sb.by_kind[btmx_pkg::REQ_INSERT], sb.by_kind[btmx_pkg::REQ_QUERY],
             sb.by_kind[btmx_pkg::REQ_CLEAR], sb.by_kind[REQ_UNUSED]);
    $display("results checked: %0d (ok %0d, empty %0d, store full %0d)",
             sb.checked, sb.by_status[btmx_pkg::STAT_OK],
             sb.by_status[btmx_pkg::STAT_EMPTY], sb.by_status[btmx_pkg::STAT_FULL]);
    if (sb.errors == 0) begin
      $display("binary_trie_max_xor_core_tb passed");
    end else begin
      $display("binary_trie_max_xor_core_tb failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/btmx_pkg.sv
rtl/core/btmx_ram.sv
rtl/core/btmx_ctrl.sv
rtl/core/btmx_dpath.sv
rtl/core/binary_trie_max_xor_core.sv
bench/binary_trie_max_xor_core_tb.sv
